// File: design/ims_pkg.sv
`timescale 1ns / 1ps

package ims_pkg;

	localparam int LATTICE_WIDTH_DEF  = 64;
	localparam int LATTICE_HEIGHT_DEF = 64;

	localparam int SITE_W     = 12;
	localparam int DRAW_W     = 16;
	localparam int THR_W      = 17;
	localparam int DE_W       = 5;
	localparam int MAG_W      = 14;
	localparam int ENG_W      = 15;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = THR_W;
	localparam int RECIP_SHIFT = 24;

	localparam logic [CFG_IDX_W-1:0] REG_THR_DE4 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_DE8 = 1'b1;
	localparam logic [THR_W-1:0]     THR_RESET   = 17'h10000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_DIVIDE,
		ST_SPLIT,
		ST_RD_C,
		ST_RD_L,
		ST_RD_R,
		ST_RD_U,
		ST_RD_D,
		ST_GATHER,
		ST_UPDATE
	} state_t;

	typedef enum logic [2:0] {
		SEL_CENTER,
		SEL_LEFT,
		SEL_RIGHT,
		SEL_UP,
		SEL_DOWN
	} rd_sel_t;

	typedef struct packed {
		logic    clr_wr;
		logic    load;
		logic    reduce;
		logic    divide;
		logic    split;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    commit;
	} ims_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} ims_sts_t;

endpackage

// File: design/ims_ctrl.sv
`timescale 1ns / 1ps

module ims_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ims_pkg::ims_sts_t sts,
	output ims_pkg::ims_cmd_t cmd
);
	import ims_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: state_d = ST_DIVIDE;
			ST_DIVIDE: state_d = ST_SPLIT;
			ST_SPLIT:  state_d = ST_RD_C;
			ST_RD_C:   state_d = ST_RD_L;
			ST_RD_L:   state_d = ST_RD_R;
			ST_RD_R:   state_d = ST_RD_U;
			ST_RD_U:   state_d = ST_RD_D;
			ST_RD_D:   state_d = ST_GATHER;
			ST_GATHER: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = SEL_CENTER;
		s_tready   = 1'b0;
		case (state_q)
			ST_CLEAR:  cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_REDUCE: cmd.reduce = 1'b1;
			ST_DIVIDE: cmd.divide = 1'b1;
			ST_SPLIT:  cmd.split = 1'b1;
			ST_RD_C: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_CENTER;
			end
			ST_RD_L: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_LEFT;
			end
			ST_RD_R: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_RIGHT;
			end
			ST_RD_U: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_UP;
			end
			ST_RD_D: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_DOWN;
			end
			ST_GATHER: ;
			ST_UPDATE: cmd.commit = sts.out_free;
			default:   ;
		endcase
	end

endmodule

// File: design/ims_dpath.sv
`timescale 1ns / 1ps

module ims_dpath #(
	parameter int LATTICE_WIDTH  = ims_pkg::LATTICE_WIDTH_DEF,
	parameter int LATTICE_HEIGHT = ims_pkg::LATTICE_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ims_pkg::ims_cmd_t                  cmd,
	output ims_pkg::ims_sts_t                  sts,
	input  logic [ims_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ims_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                               cfg_wen,
	input  logic [ims_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ims_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ims_pkg::*;

	localparam int CELLS       = LATTICE_WIDTH * LATTICE_HEIGHT;
	localparam int AW          = $clog2(CELLS);
	localparam int CW          = $clog2(LATTICE_WIDTH);
	localparam int RW          = $clog2(LATTICE_HEIGHT);
	localparam int RECIP_CELLS = (1 << RECIP_SHIFT) / CELLS;
	localparam int RECIP_WIDTH = (1 << RECIP_SHIFT) / LATTICE_WIDTH;
	localparam int PM_W        = SITE_W + RECIP_SHIFT;
	localparam int PC_W        = AW + RECIP_SHIFT;
	localparam logic [DE_W-1:0] DE_FOUR  = 5'd4;
	localparam logic [DE_W-1:0] DE_EIGHT = 5'd8;
	localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(CELLS);
	localparam logic [ENG_W-1:0] ENG_RESET = ENG_W'(-2 * CELLS);

	logic mem [CELLS];

	logic [AW-1:0]     clr_addr_q;
	logic [THR_W-1:0]  thr4_q;
	logic [THR_W-1:0]  thr8_q;
	logic [SITE_W-1:0] site_q;
	logic [DRAW_W-1:0] draw_q;
	logic [PM_W-1:0]   prod_mod_q;
	logic [AW-1:0]     k_q;
	logic [PC_W-1:0]   prod_col_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic              rdata_q;
	logic              rd_vld_q;
	rd_sel_t           rd_sel_q;
	logic [4:0]        spins_q;
	logic [MAG_W-1:0]  mag_q;
	logic [ENG_W-1:0]  eng_q;
	logic              out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [SITE_W-1:0] qm_c;
	logic [31:0]       rm_c;
	logic [AW-1:0]     q_c;
	logic [AW-1:0]     rr_c;
	logic [AW-1:0]     raddr_c;
	logic [2:0]        n1_c;
	logic [DE_W-1:0]   t_c;
	logic [DE_W-1:0]   de_c;
	logic              accept_c;
	logic              we_c;
	logic [AW-1:0]     waddr_c;
	logic              wdata_c;

	assign sts.clr_last = (clr_addr_q == AW'(CELLS - 1));
	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

	// site modulo cell count, reciprocal estimate plus one correction
	always_comb begin
		qm_c = prod_mod_q[PM_W-1:RECIP_SHIFT];
		rm_c = 32'(site_q) - 32'(qm_c) * 32'(CELLS);
		if (rm_c >= 32'(CELLS)) begin
			rm_c = rm_c - 32'(CELLS);
		end
	end

	// split site into row and column
	always_comb begin
		q_c  = prod_col_q[PC_W-1:RECIP_SHIFT];
		rr_c = k_q - q_c * AW'(LATTICE_WIDTH);
	end

	always_comb begin
		case (cmd.rd_sel)
			SEL_CENTER: raddr_c = k_q;
			SEL_LEFT:   raddr_c = (col_q == '0) ? k_q + AW'(LATTICE_WIDTH - 1) : k_q - AW'(1);
			SEL_RIGHT:  raddr_c = (col_q == CW'(LATTICE_WIDTH - 1)) ?
			                      k_q - AW'(LATTICE_WIDTH - 1) : k_q + AW'(1);
			SEL_UP:     raddr_c = (row_q == '0) ?
			                      k_q + AW'(CELLS - LATTICE_WIDTH) : k_q - AW'(LATTICE_WIDTH);
			SEL_DOWN:   raddr_c = (row_q == RW'(LATTICE_HEIGHT - 1)) ?
			                      k_q - AW'(CELLS - LATTICE_WIDTH) : k_q + AW'(LATTICE_WIDTH);
			default:    raddr_c = k_q;
		endcase
	end

	// energy change and acceptance
	always_comb begin
		n1_c = 3'($countones(spins_q[4:1]));
		t_c  = {n1_c, 2'b00};
		de_c = spins_q[0] ? t_c - DE_EIGHT : DE_EIGHT - t_c;
		if (de_c == DE_FOUR) begin
			accept_c = {1'b0, draw_q} < thr4_q;
		end else if (de_c == DE_EIGHT) begin
			accept_c = {1'b0, draw_q} < thr8_q;
		end else begin
			accept_c = 1'b1;
		end
	end

	always_comb begin
		we_c    = cmd.clr_wr || (cmd.commit && accept_c);
		waddr_c = cmd.clr_wr ? clr_addr_q : k_q;
		wdata_c = cmd.clr_wr ? 1'b1 : !spins_q[0];
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			thr4_q     <= THR_RESET;
			thr8_q     <= THR_RESET;
			rd_vld_q   <= 1'b0;
			mag_q      <= MAG_RESET;
			eng_q      <= ENG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr && !sts.clr_last) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cfg_wen) begin
				case (cfg_index)
					REG_THR_DE4: thr4_q <= cfg_data;
					REG_THR_DE8: thr8_q <= cfg_data;
					default:     ;
				endcase
			end
			rd_vld_q <= cmd.rd_en;
			if (cmd.commit && accept_c) begin
				mag_q <= spins_q[0] ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
				eng_q <= eng_q + {{(ENG_W - DE_W){de_c[DE_W-1]}}, de_c};
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			site_q     <= s_tdata[SITE_W-1:0];
			draw_q     <= s_tdata[SITE_W+DRAW_W-1:SITE_W];
			prod_mod_q <= PM_W'(s_tdata[SITE_W-1:0]) * PM_W'(RECIP_CELLS);
		end
		if (cmd.reduce) begin
			k_q <= AW'(rm_c);
		end
		if (cmd.divide) begin
			prod_col_q <= PC_W'(k_q) * PC_W'(RECIP_WIDTH);
		end
		if (cmd.split) begin
			if (rr_c >= AW'(LATTICE_WIDTH)) begin
				col_q <= CW'(rr_c - AW'(LATTICE_WIDTH));
				row_q <= RW'(q_c + AW'(1));
			end else begin
				col_q <= CW'(rr_c);
				row_q <= RW'(q_c);
			end
		end
		rd_sel_q <= cmd.rd_sel;
		if (rd_vld_q) begin
			case (rd_sel_q)
				SEL_CENTER: spins_q[0] <= rdata_q;
				SEL_LEFT:   spins_q[1] <= rdata_q;
				SEL_RIGHT:  spins_q[2] <= rdata_q;
				SEL_UP:     spins_q[3] <= rdata_q;
				SEL_DOWN:   spins_q[4] <= rdata_q;
				default:    ;
			endcase
		end
		if (cmd.commit) begin
			out_data_q <= {
				{(M_TDATA_W - 1 - DE_W - MAG_W - ENG_W){1'b0}},
				accept_c ? eng_q + {{(ENG_W - DE_W){de_c[DE_W-1]}}, de_c} : eng_q,
				accept_c ? (spins_q[0] ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2)) : mag_q,
				de_c,
				accept_c
			};
		end
	end

endmodule

// File: design/ising_metropolis_spin_flip.sv
`timescale 1ns / 1ps

// channel   direction  word fields (low bit up)
// s_*       in         site_index[11:0], random_draw[27:12]
// m_*       out        flipped[0], delta_energy[5:1], magnetization[19:6],
//                      total_energy[34:20]
// cfg_*     in         0 accept_threshold_de4, 1 accept_threshold_de8
//
// an item runs through the states REDUCE, DIVIDE, SPLIT, RD_C, RD_L, RD_R, RD_U, RD_D,
// GATHER and UPDATE, and the next word is taken in the cycle after the result is
// registered: REDUCE, DIVIDE and SPLIT reduce the site to column and row, the single-port
// lattice memory serves the site and its four neighbors one read per cycle, then one write
// after reset a clearing pass writes +1 to all LATTICE_WIDTH*LATTICE_HEIGHT
// sites, one per cycle, with s_tready low
// a result waiting on m_tready holds the block before its write-back

module ising_metropolis_spin_flip #(
	parameter int LATTICE_WIDTH  = ims_pkg::LATTICE_WIDTH_DEF,
	parameter int LATTICE_HEIGHT = ims_pkg::LATTICE_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ims_pkg::S_TDATA_W-1:0]  s_tdata,  // site_index, random_draw
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ims_pkg::M_TDATA_W-1:0]  m_tdata,  // flipped, delta_energy,
	                                                 // magnetization, total_energy
	input  logic                           cfg_wen,
	input  logic [ims_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ims_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ims_pkg::*;

	ims_cmd_t cmd;
	ims_sts_t sts;

	ims_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ims_dpath #(
		.LATTICE_WIDTH  (LATTICE_WIDTH),
		.LATTICE_HEIGHT (LATTICE_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result committed over an untaken word");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while an item is in flight");

	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("output valid without a commit");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!cmd.commit && !cmd.rd_en && !cmd.clr_wr))
		else $error("load overlaps other datapath work");

endmodule
